[hdl/skr_pkg.sv]
package skr_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = SEG_AW + 1;
  localparam int CW           = 13;
  localparam int POS_W        = 12;
  localparam int LW           = CW + 2;

  localparam logic [CW-1:0] ATLAS_W_RESET = CW'(512);
  localparam logic [CW-1:0] ATLAS_H_RESET = CW'(512);

  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic REG_ATLAS_W = 1'b0;
  localparam logic REG_ATLAS_H = 1'b1;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] w;
  } seg_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [SEG_AW-1:0] addr;
    seg_t              data;
  } seg_wr_t;

  typedef struct packed {
    logic              bank;
    logic [SEG_AW-1:0] addr;
  } seg_rd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SC_RD,
    ST_SC_EV,
    ST_RB_RD,
    ST_RB_EV,
    ST_RB_NEW,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage

[hdl/skr_in_if.sv]
interface skr_in_if import skr_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          kind;
  logic [CW-1:0] rect_width;
  logic [CW-1:0] rect_height;

  modport source (output valid, kind, rect_width, rect_height, input ready);
  modport sink (input valid, kind, rect_width, rect_height, output ready);
endinterface

[hdl/skr_out_if.sv]
interface skr_out_if import skr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             placed;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;

  modport source (output valid, placed, pos_x, pos_y, input ready);
  modport sink (input valid, placed, pos_x, pos_y, output ready);
endinterface

[hdl/skr_seg_store.sv]
module skr_seg_store import skr_pkg::*; (
  input  logic    clk,
  input  seg_wr_t wr,
  input  seg_rd_t rd,
  output seg_t    rd_data
);

  seg_t bank0 [MAX_SEGMENTS];
  seg_t bank1 [MAX_SEGMENTS];
  seg_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en && !wr.bank) begin
      bank0[wr.addr] <= wr.data;
    end
    if (wr.en && wr.bank) begin
      bank1[wr.addr] <= wr.data;
    end
    rd_data_r <= rd.bank ? bank1[rd.addr] : bank0[rd.addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/skr_cfg_regs.sv]
module skr_cfg_regs import skr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output logic [CW-1:0] atlas_width,
  output logic [CW-1:0] atlas_height
);

  logic [CW-1:0] aw_r;
  logic [CW-1:0] ah_r;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r <= ATLAS_W_RESET;
      ah_r <= ATLAS_H_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_ATLAS_W) begin
        aw_r <= pwdata[CW-1:0];
      end else begin
        ah_r <= pwdata[CW-1:0];
      end
    end
  end

  assign prdata       = (paddr[2] == REG_ATLAS_H) ? {(32-CW)'(0), ah_r} : {(32-CW)'(0), aw_r};
  assign atlas_width  = aw_r;
  assign atlas_height = ah_r;

endmodule

[hdl/skyline_rect_packer.sv]
// Channel | Dir | Beat
// in_ch   | in  | kind, rect_width, rect_height
// out_ch  | out | placed, pos_x, pos_y
// apb     | in  | atlas_width at 0x0, atlas_height at 0x4
// Clear and a reject without a scan (zero width or full store) go from acceptance to the result state.
// Place: the scan reads each segment visited (each start walks its covering run), then
// the rebuild reads each segment again and adds the new one, through one store read port.
// After reset, ST_INIT writes the initial segment before the first beat is taken.
// A result waits in the output register; the next beat is taken while it stalls.
module skyline_rect_packer import skr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  skr_in_if.sink        in_ch,
  skr_out_if.source     out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [CW-1:0] atlas_width;
  logic [CW-1:0] atlas_height;
  seg_wr_t       wr;
  seg_rd_t       rd;
  seg_t          d;

  skr_cfg_regs u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .atlas_width, .atlas_height
  );

  skr_seg_store u_store (.clk, .wr, .rd, .rd_data(d));

  state_t            state_r, state_nxt;
  logic              bank_r, bank_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  s_r, s_nxt, k_r, k_nxt, j_r, j_nxt, wcnt_r, wcnt_nxt;
  logic [CW-1:0]     top_r, top_nxt, sx_r, sx_nxt, sw_r, sw_nxt;
  logic signed [LW-1:0] left_r, left_nxt;
  logic              first_r, first_nxt, found_r, found_nxt;
  logic [CNT_W-1:0]  best_s_r, best_s_nxt;
  logic [CW-1:0]     best_top_r, best_top_nxt, best_w_r, best_w_nxt, best_x_r, best_x_nxt;
  logic [CW:0]       best_end_r, best_end_nxt;
  logic [CW-1:0]     req_w_r, req_w_nxt, req_h_r, req_h_nxt;
  logic              trim_r, trim_nxt, pend_v_r, pend_v_nxt;
  seg_t              pend_r, pend_nxt;
  logic              res_placed_r, res_placed_nxt;
  logic [POS_W-1:0]  res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic              out_valid_r, out_valid_nxt, out_placed_r, out_placed_nxt;
  logic [POS_W-1:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  logic              fail, succ, done_cand, upd;
  logic [CW-1:0]     top_c, xs, ws, end_n, cut;
  logic [CW:0]       end_c;
  logic signed [LW-1:0] left_c, nw;
  logic              in_v;
  seg_t              in_seg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      bank_r      <= 1'b0;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
      s_r         <= '0;
      k_r         <= '0;
      j_r         <= '0;
      wcnt_r      <= '0;
      first_r     <= 1'b1;
      found_r     <= 1'b0;
      trim_r      <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      s_r         <= s_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      wcnt_r      <= wcnt_nxt;
      first_r     <= first_nxt;
      found_r     <= found_nxt;
      trim_r      <= trim_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    sx_r         <= sx_nxt;
    sw_r         <= sw_nxt;
    left_r       <= left_nxt;
    best_s_r     <= best_s_nxt;
    best_top_r   <= best_top_nxt;
    best_w_r     <= best_w_nxt;
    best_x_r     <= best_x_nxt;
    best_end_r   <= best_end_nxt;
    req_w_r      <= req_w_nxt;
    req_h_r      <= req_h_nxt;
    pend_r       <= pend_nxt;
    res_placed_r <= res_placed_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    out_placed_r <= out_placed_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    bank_nxt       = bank_r;
    count_nxt      = count_r;
    s_nxt          = s_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    wcnt_nxt       = wcnt_r;
    top_nxt        = top_r;
    sx_nxt         = sx_r;
    sw_nxt         = sw_r;
    left_nxt       = left_r;
    first_nxt      = first_r;
    found_nxt      = found_r;
    best_s_nxt     = best_s_r;
    best_top_nxt   = best_top_r;
    best_w_nxt     = best_w_r;
    best_x_nxt     = best_x_r;
    best_end_nxt   = best_end_r;
    req_w_nxt      = req_w_r;
    req_h_nxt      = req_h_r;
    trim_nxt       = trim_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    res_placed_nxt = res_placed_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_placed_nxt = out_placed_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    in_ch.ready    = 1'b0;
    wr             = '0;
    rd.bank        = bank_r;
    rd.addr        = '0;
    fail           = 1'b0;
    succ           = 1'b0;
    done_cand      = 1'b0;
    upd            = 1'b0;
    top_c          = (first_r || d.y > top_r) ? d.y : top_r;
    xs             = first_r ? d.x : sx_r;
    ws             = first_r ? d.w : sw_r;
    left_c         = (first_r ? $signed({2'b00, req_w_r}) : left_r) - $signed({2'b00, d.w});
    end_c          = {1'b0, top_c} + {1'b0, req_h_r};
    end_n          = best_x_r + req_w_r;
    cut            = end_n - d.x;
    nw             = $signed({2'b00, d.w}) - $signed({2'b00, cut});
    in_v           = 1'b0;
    in_seg         = d;

    case (state_r)
      ST_INIT: begin
        wr.en     = 1'b1;
        wr.bank   = 1'b0;
        wr.data   = '{x: '0, y: '0, w: ATLAS_W_RESET};
        bank_nxt  = 1'b0;
        count_nxt = CNT_W'(1);
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          res_x_nxt = '0;
          res_y_nxt = '0;
          req_w_nxt = in_ch.rect_width;
          req_h_nxt = in_ch.rect_height;
          if (in_ch.kind == KIND_CLEAR) begin
            wr.en          = 1'b1;
            wr.bank        = bank_r;
            wr.data        = '{x: '0, y: '0, w: atlas_width};
            count_nxt      = CNT_W'(1);
            res_placed_nxt = 1'b1;
            state_nxt      = ST_DONE;
          end else if (in_ch.rect_width == '0 || count_r == CNT_W'(MAX_SEGMENTS)) begin
            res_placed_nxt = 1'b0;
            state_nxt      = ST_DONE;
          end else begin
            s_nxt     = '0;
            k_nxt     = '0;
            first_nxt = 1'b1;
            found_nxt = 1'b0;
            state_nxt = ST_SC_RD;
          end
        end
      end
      ST_SC_RD: begin
        rd.addr   = k_r[SEG_AW-1:0];
        state_nxt = ST_SC_EV;
      end
      ST_SC_EV: begin
        if (first_r && ({1'b0, d.x} + {1'b0, req_w_r}) > {1'b0, atlas_width}) begin
          fail = 1'b1;
        end
        if (end_c > {1'b0, atlas_height}) begin
          fail = 1'b1;
        end
        if (fail) begin
          done_cand = 1'b1;
        end else if (left_c > LW'(0)) begin
          if (k_r + CNT_W'(1) >= count_r) begin
            done_cand = 1'b1;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            top_nxt   = top_c;
            left_nxt  = left_c;
            sx_nxt    = xs;
            sw_nxt    = ws;
            first_nxt = 1'b0;
            state_nxt = ST_SC_RD;
          end
        end else begin
          succ      = 1'b1;
          done_cand = 1'b1;
        end
        if (succ && (!found_r || end_c < best_end_r ||
            (end_c == best_end_r && ws < best_w_r))) begin
          upd          = 1'b1;
          found_nxt    = 1'b1;
          best_s_nxt   = s_r;
          best_top_nxt = top_c;
          best_end_nxt = end_c;
          best_w_nxt   = ws;
          best_x_nxt   = xs;
        end
        if (done_cand) begin
          s_nxt     = s_r + CNT_W'(1);
          k_nxt     = s_r + CNT_W'(1);
          first_nxt = 1'b1;
          if (s_r + CNT_W'(1) >= count_r) begin
            if (found_r || upd) begin
              j_nxt      = '0;
              wcnt_nxt   = '0;
              pend_v_nxt = 1'b0;
              trim_nxt   = 1'b0;
              state_nxt  = ST_RB_RD;
            end else begin
              res_placed_nxt = 1'b0;
              state_nxt      = ST_DONE;
            end
          end else begin
            state_nxt = ST_SC_RD;
          end
        end
      end
      ST_RB_RD: begin
        if (j_r == count_r + CNT_W'(1)) begin
          state_nxt = ST_FLUSH;
        end else if (j_r == best_s_r) begin
          state_nxt = ST_RB_NEW;
        end else begin
          rd.addr   = (j_r < best_s_r) ? j_r[SEG_AW-1:0] : SEG_AW'(j_r - CNT_W'(1));
          state_nxt = ST_RB_EV;
        end
      end
      ST_RB_EV: begin
        in_v = 1'b1;
        if (trim_r) begin
          if (d.x < end_n) begin
            if (nw <= LW'(0)) begin
              in_v = 1'b0;
            end else begin
              in_seg   = '{x: end_n, y: d.y, w: nw[CW-1:0]};
              trim_nxt = 1'b0;
            end
          end else begin
            trim_nxt = 1'b0;
          end
        end
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = ST_RB_RD;
      end
      ST_RB_NEW: begin
        in_v      = 1'b1;
        in_seg    = '{x: best_x_r, y: best_top_r + req_h_r, w: req_w_r};
        trim_nxt  = 1'b1;
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = ST_RB_RD;
      end
      ST_FLUSH: begin
        wr.en          = 1'b1;
        wr.bank        = !bank_r;
        wr.addr        = wcnt_r[SEG_AW-1:0];
        wr.data        = pend_r;
        count_nxt      = wcnt_r + CNT_W'(1);
        bank_nxt       = !bank_r;
        res_placed_nxt = 1'b1;
        res_x_nxt      = best_x_r[POS_W-1:0];
        res_y_nxt      = best_top_r[POS_W-1:0];
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_placed_nxt = res_placed_r;
          out_x_nxt      = res_x_r;
          out_y_nxt      = res_y_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // merge runs of equal height, emit finished segments
    if (in_v) begin
      if (!pend_v_r) begin
        pend_v_nxt = 1'b1;
        pend_nxt   = in_seg;
      end else if (in_seg.y == pend_r.y) begin
        pend_nxt.w = pend_r.w + in_seg.w;
      end else begin
        wr.en    = 1'b1;
        wr.bank  = !bank_r;
        wr.addr  = wcnt_r[SEG_AW-1:0];
        wr.data  = pend_r;
        wcnt_nxt = wcnt_r + CNT_W'(1);
        pend_nxt = in_seg;
      end
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.placed = out_placed_r;
  assign out_ch.pos_x  = out_x_r;
  assign out_ch.pos_y  = out_y_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_placed_r |-> out_x_r == '0 && out_y_r == '0)
    else $error("rejected beat carries a position");

  a_rebuild_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RB_EV || state_r == ST_RB_NEW) |-> wcnt_r <= j_r && j_r <= count_r)
    else $error("rebuild index out of range");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.kind == KIND_PLACE &&
    count_r == CNT_W'(MAX_SEGMENTS) |=> state_r == ST_DONE && !res_placed_r)
    else $error("place accepted with full store");

endmodule

[tb/sv/skyline_rect_packer_tb.sv]
`timescale 1ns / 1ps

import skr_pkg::*;

typedef struct packed {
  logic             placed;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
} placement_t;

class skyline_scoreboard;
  int unsigned atlas_w;
  int unsigned atlas_h;
  int sx[MAX_SEGMENTS];
  int sy[MAX_SEGMENTS];
  int sw[MAX_SEGMENTS];
  int nseg;
  placement_t placements_due[$];
  int errors;
  int beats_in;
  int beats_out;
  int n_placed;
  int n_rejected;

  function new();
    atlas_w = 32'(ATLAS_W_RESET);
    atlas_h = 32'(ATLAS_H_RESET);
    rebuild_skyline();
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    n_placed = 0;
    n_rejected = 0;
  endfunction

  function void rebuild_skyline();
    sx[0] = 0;
    sy[0] = 0;
    sw[0] = atlas_w;
    nseg = 1;
  endfunction

  function void write_reg(logic idx, logic [31:0] val);
    if (idx == REG_ATLAS_W) atlas_w = val & 32'h1FFF;
    else atlas_h = val & 32'h1FFF;
  endfunction

  function void seg_ins(int at, int x, int y, int w);
    for (int k = nseg; k > at; k--) begin
      sx[k] = sx[k-1];
      sy[k] = sy[k-1];
      sw[k] = sw[k-1];
    end
    sx[at] = x;
    sy[at] = y;
    sw[at] = w;
    nseg++;
  endfunction

  function void seg_del(int at);
    for (int k = at; k < nseg - 1; k++) begin
      sx[k] = sx[k+1];
      sy[k] = sy[k+1];
      sw[k] = sw[k+1];
    end
    nseg--;
  endfunction

  function int fit_top(int s, int w, int h);
    int top;
    int left;
    int k;
    top = sy[s];
    left = w;
    k = s;
    if (sx[s] + w > int'(atlas_w)) return -1;
    while (left > 0) begin
      if (k >= nseg) return -1;
      if (sy[k] > top) top = sy[k];
      if (top + h > int'(atlas_h)) return -1;
      left -= sw[k];
      k++;
    end
    return top;
  endfunction

  function void note_input(logic kind, logic [CW-1:0] rw, logic [CW-1:0] rh);
    placement_t r;
    int w;
    int h;
    int top;
    int best_s;
    int best_top;
    int best_end;
    int best_w;
    int best_x;
    bit found;
    int k;
    int cut;
    r = '0;
    w = int'(rw);
    h = int'(rh);
    found = 0;
    best_s = 0;
    best_top = 0;
    best_end = 0;
    best_w = 0;
    best_x = 0;
    beats_in++;
    if (kind == KIND_CLEAR) begin
      rebuild_skyline();
      r.placed = 1'b1;
    end else if (w != 0 && nseg < MAX_SEGMENTS) begin
      for (int s = 0; s < nseg; s++) begin
        top = fit_top(s, w, h);
        if (top >= 0) begin
          if (!found || top + h < best_end || (top + h == best_end && sw[s] < best_w)) begin
            found = 1;
            best_s = s;
            best_top = top;
            best_end = top + h;
            best_w = sw[s];
            best_x = sx[s];
          end
        end
      end
      if (found) begin
        seg_ins(best_s, best_x, best_top + h, w);
        for (k = best_s + 1; k < nseg; k++) begin
          if (sx[k] < sx[k-1] + sw[k-1]) begin
            cut = sx[k-1] + sw[k-1] - sx[k];
            sx[k] += cut;
            sw[k] -= cut;
            if (sw[k] <= 0) begin
              seg_del(k);
              k--;
            end else break;
          end else break;
        end
        for (k = 0; k < nseg - 1; k++) begin
          if (sy[k] == sy[k+1]) begin
            sw[k] += sw[k+1];
            seg_del(k + 1);
            k--;
          end
        end
        r.placed = 1'b1;
        r.pos_x = best_x[POS_W-1:0];
        r.pos_y = best_top[POS_W-1:0];
      end
    end
    if (kind != KIND_CLEAR) begin
      if (r.placed) n_placed++;
      else n_rejected++;
    end
    placements_due.push_back(r);
  endfunction

  function void check_result(logic placed, logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    placement_t e;
    beats_out++;
    if (placements_due.size() == 0) begin
      $error("unexpected result beat placed=%0d pos_x=%0d pos_y=%0d", placed, px, py);
      errors++;
      return;
    end
    e = placements_due.pop_front();
    if (placed !== e.placed) begin
      $error("placed: expected %0d, actual %0d", e.placed, placed);
      errors++;
    end
    if (px !== e.pos_x) begin
      $error("pos_x: expected %0d, actual %0d", e.pos_x, px);
      errors++;
    end
    if (py !== e.pos_y) begin
      $error("pos_y: expected %0d, actual %0d", e.pos_y, py);
      errors++;
    end
  endfunction

  function int pending();
    return placements_due.size();
  endfunction
endclass

module skyline_rect_packer_tb;
  localparam longint CYCLE_LIMIT = 40_000_000;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  skr_in_if  in_ch();
  skr_out_if out_ch();

  skyline_rect_packer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  skyline_scoreboard sb = new();
  bit     no_idle;
  longint cycles;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_PLACE;
    in_ch.rect_width = '0;
    in_ch.rect_height = '0;
    out_ch.ready = 1'b0;
    no_idle = 1'b0;
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[skyline_rect_packer] ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.placed, out_ch.pos_x, out_ch.pos_y);

  initial begin : result_sink
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_rect(logic kind, logic [CW-1:0] w, logic [CW-1:0] h);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.rect_width <= w;
    in_ch.rect_height <= h;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(kind, w, h);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_atlas(int unsigned w, int unsigned h);
    drain();
    write_reg(REG_ATLAS_W, w);
    write_reg(REG_ATLAS_H, h);
    send_rect(KIND_CLEAR, '0, '0);
  endtask

  task automatic random_phase(int n);
    int unsigned aw;
    int unsigned ah;
    int unsigned sel;
    logic [CW-1:0] w;
    logic [CW-1:0] h;
    aw = sb.atlas_w;
    ah = sb.atlas_h;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        send_rect(KIND_CLEAR, CW'($urandom_range(0, 8191)), CW'($urandom_range(0, 8191)));
      end else begin
        if (sel < 14) begin
          w = CW'($urandom_range(0, 8191));
          h = CW'($urandom_range(0, 8191));
        end else begin
          w = CW'($urandom_range(1, (aw / 4 > 1) ? aw / 4 : 1));
          h = CW'($urandom_range(0, (ah / 6 > 1) ? ah / 6 : 1));
        end
        send_rect(KIND_PLACE, w, h);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned aw_set[7];
    int unsigned ah_set[7];
    aw_set = '{512, 4096, 8191, 64, 1, 300, 1000};
    ah_set = '{512, 4096, 8191, 32, 1, 1000, 200};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_rect(KIND_PLACE, 13'd0, 13'd5);
    send_rect(KIND_PLACE, 13'd1, 13'd0);
    send_rect(KIND_PLACE, 13'd100, 13'd50);
    send_rect(KIND_PLACE, 13'd100, 13'd0);
    send_rect(KIND_PLACE, 13'd513, 13'd1);
    send_rect(KIND_PLACE, 13'd1, 13'd513);
    send_rect(KIND_PLACE, 13'd8191, 13'd8191);
    send_rect(KIND_PLACE, 13'd4096, 13'd4096);
    send_rect(KIND_CLEAR, 13'd0, 13'd0);
    send_rect(KIND_PLACE, 13'd512, 13'd512);
    send_rect(KIND_PLACE, 13'd1, 13'd1);
    send_rect(KIND_CLEAR, 13'd8191, 13'd8191);

    set_atlas(8191, 8191);
    send_rect(KIND_PLACE, 13'd5000, 13'd1);
    send_rect(KIND_PLACE, 13'd100, 13'd4500);
    send_rect(KIND_PLACE, 13'd3000, 13'd8191);
    set_atlas(1, 1);
    send_rect(KIND_PLACE, 13'd1, 13'd1);
    send_rect(KIND_PLACE, 13'd1, 13'd0);
    send_rect(KIND_PLACE, 13'd1, 13'd1);

    // fill the segment store with alternating tall and short columns
    set_atlas(300, 4096);
    no_idle = 1'b1;
    for (int i = 0; i < MAX_SEGMENTS; i++)
      send_rect(KIND_PLACE, 13'd1, (i % 2 == 0) ? 13'd1000 : 13'd1);
    send_rect(KIND_PLACE, 13'd1, 13'd1);
    no_idle = 1'b0;

    for (int p = 0; p < 7; p++) begin
      set_atlas(aw_set[p], ah_set[p]);
      no_idle = (p % 3 == 2);
      random_phase(44);
    end
    no_idle = 1'b0;

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d input beats, %0d placements, %0d rejects, %0d result beats",
             sb.beats_in, sb.n_placed, sb.n_rejected, sb.beats_out);
    $display("atlas settings from 1x1 to 8191x8191, zero sizes, store full and clears");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[skyline_rect_packer] OK");
    end else begin
      if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
      $display("[skyline_rect_packer] ERROR");
    end
    $finish;
  end
endmodule
